// File: sv/bms_pkg.sv
// shared sizes, register codes and the scan position record of the majority smoother
package bms_pkg;

  // largest map the column stores are sized for
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // position counters and the clamped size values
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // width of the column and row fields of a result word
  localparam int IDX_W = 10;

  // position of the pixel at the input and what it will cause
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             bank;        // bank the arriving column is written into
    logic             has_smooth;  // pixel of the column before is emitted
    logic             border;      // that pixel sits on the map border
    logic             has_pass;    // pixel is on the last column, emitted at once
    logic             frame_end;   // last row of the column
  } scan_pos_t;

endpackage

// File: sv/bms_in_if.sv
// handshake channel that carries one raw noise bit per word
interface bms_in_if;
  logic valid;
  logic ready;
  logic noise_bit;

  modport source (output valid, output noise_bit, input ready);
  modport sink   (input valid, input noise_bit, output ready);
endinterface

// File: sv/bms_out_if.sv
// handshake channel that carries one smoothed pixel word
interface bms_out_if import bms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pixel_value;
  logic [IDX_W-1:0] column_index;
  logic [IDX_W-1:0] row_index;
  logic             last_of_run;
  logic             frame_end;

  modport source (output valid, output pixel_value, output column_index, output row_index,
                  output last_of_run, output frame_end, input ready);
  modport sink   (input valid, input pixel_value, input column_index, input row_index,
                  input last_of_run, input frame_end, output ready);
endinterface

// File: sv/bms_ctrl.sv
// size registers and scan position counters
module bms_ctrl import bms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 accept,
  output scan_pos_t            pos,
  output logic                 restart
);

  logic [CFG_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             bank_r, bank_nxt;

  logic [DIM_W-1:0] w, h;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;
  logic [DIM_W-1:0] x_inc, y_inc;

  // zero acts as one, anything above the store size acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > maxv) r = DIM_W'(maxv);
    else r = DIM_W'(v);
    return r;
  endfunction

  assign w = clamp_size(width_r, MAX_WIDTH);
  assign h = clamp_size(height_r, MAX_HEIGHT);

  // current position, folded back into the map
  assign x     = (DIM_W'(col_r) >= w) ? '0 : col_r;
  assign y     = (DIM_W'(row_r) >= h) ? '0 : row_r;
  assign x_inc = DIM_W'(x) + DIM_W'(1);
  assign y_inc = DIM_W'(y) + DIM_W'(1);

  // what the pixel at the input causes
  always_comb begin
    pos.col        = x;
    pos.row        = y;
    pos.bank       = bank_r;
    pos.has_smooth = (x != '0);
    pos.border     = (x == COL_W'(1)) || (y == '0) || (y_inc >= h);
    pos.has_pass   = (x_inc == w);
    pos.frame_end  = (y_inc == h);
  end

  assign restart = cfg_wr_en &&
                   ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  // scan order: row inner, column outer; banks swap at each column end
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    bank_nxt = bank_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (y_inc >= h) begin
        row_nxt  = '0;
        bank_nxt = ~bank_r;
        col_nxt  = (x_inc >= w) ? '0 : COL_W'(x_inc);
      end else begin
        row_nxt = ROW_W'(y_inc);
        col_nxt = x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(1024);
      height_r <= CFG_W'(1024);
      col_r    <= '0;
      row_r    <= '0;
      bank_r   <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH)) width_r <= cfg_wdata;
      if (cfg_wr_en && (cfg_index == REG_IMAGE_HEIGHT)) height_r <= cfg_wdata;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// File: sv/bms_column_store.sv
// raw column banks and smoothed column memory with registered reads
module bms_column_store import bms_pkg::*; (
  input  logic             clk,
  input  logic             accept,
  input  scan_pos_t        pos,
  input  logic             noise_bit,
  input  logic             sm_wr_en,
  input  logic [ROW_W-1:0] sm_wr_row,
  input  logic             sm_wr_bit,
  output logic             raw_centre,
  output logic             raw_below,
  output logic             smoothed_left
);

  localparam int RAW_DEPTH = 2 ** (ROW_W + 1);

  // two column banks side by side, bank bit on top of the address
  logic raw_mem [RAW_DEPTH];
  logic sm_mem  [MAX_HEIGHT];

  logic [ROW_W-1:0] row_below;
  logic             raw_centre_r, raw_below_r, smoothed_left_r;

  // points past the last row there, where the value is never used
  assign row_below = pos.row + ROW_W'(1);

  // arriving bit into one bank, the column being emitted read from the other
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_mem[{pos.bank, pos.row}] <= noise_bit;
      raw_centre_r                 <= raw_mem[{~pos.bank, pos.row}];
      raw_below_r                  <= raw_mem[{~pos.bank, row_below}];
      smoothed_left_r              <= sm_mem[pos.row];
    end
  end

  // smoothed values of the column just emitted
  always_ff @(posedge clk) begin
    if (sm_wr_en) sm_mem[sm_wr_row] <= sm_wr_bit;
  end

  assign raw_centre    = raw_centre_r;
  assign raw_below     = raw_below_r;
  assign smoothed_left = smoothed_left_r;

endmodule

// File: sv/bms_vote.sv
// input register, five point majority vote and result register
module bms_vote import bms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bms_in_if.sink           in_ch,
  bms_out_if.source        out_ch,
  input  scan_pos_t        pos,
  input  logic             restart,
  input  logic             raw_centre,
  input  logic             raw_below,
  input  logic             smoothed_left,
  output logic             sm_wr_en,
  output logic [ROW_W-1:0] sm_wr_row,
  output logic             sm_wr_bit
);

  // input register, aligned with the store read data
  logic      s1_valid_r;
  scan_pos_t s1_pos_r;
  logic      s1_bit_r;

  // result register: up to two pending words per pixel
  logic             ob_smooth_r, ob_pass_r;
  logic             ob_val_r, ob_bit_r, ob_fend_r;
  logic [COL_W-1:0] ob_col_r;
  logic [ROW_W-1:0] ob_row_r;

  logic             up_nb_r;

  logic [2:0]       sum;
  logic             vote;
  logic             ob_free, advance, accept, out_take;
  logic [COL_W-1:0] col_sel;

  // majority of centre, up, down, left and right
  assign sum  = 3'(raw_centre) + 3'(up_nb_r) + 3'(raw_below) + 3'(smoothed_left)
              + 3'(s1_bit_r);
  assign vote = s1_pos_r.border ? raw_centre : (sum >= 3'd3);

  // handshake between the stages
  assign out_take     = out_ch.valid && out_ch.ready;
  assign ob_free      = !(ob_smooth_r || ob_pass_r) ||
                        (out_ch.ready && (ob_smooth_r ^ ob_pass_r));
  assign advance      = s1_valid_r && ob_free;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;

  // smoothed value goes back into the column memory
  assign sm_wr_en  = advance && s1_pos_r.has_smooth;
  assign sm_wr_row = s1_pos_r.row;
  assign sm_wr_bit = vote;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r <= pos;
      s1_bit_r <= in_ch.noise_bit;
    end
  end

  // pending flags of the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_smooth_r <= 1'b0;
      ob_pass_r   <= 1'b0;
    end else if (advance) begin
      ob_smooth_r <= s1_pos_r.has_smooth;
      ob_pass_r   <= s1_pos_r.has_pass;
    end else if (out_take) begin
      if (ob_smooth_r) ob_smooth_r <= 1'b0;
      else ob_pass_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ob_val_r  <= vote;
      ob_bit_r  <= s1_bit_r;
      ob_fend_r <= s1_pos_r.frame_end;
      ob_col_r  <= s1_pos_r.col;
      ob_row_r  <= s1_pos_r.row;
    end
  end

  // last smoothed value, the up neighbour of the next pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_nb_r <= 1'b0;
    end else if (restart) begin
      up_nb_r <= 1'b0;
    end else if (sm_wr_en) begin
      up_nb_r <= vote;
    end
  end

  // smoothed word of the column before goes out ahead of the passed-through one
  assign col_sel             = ob_smooth_r ? (ob_col_r - COL_W'(1)) : ob_col_r;
  assign out_ch.valid        = ob_smooth_r || ob_pass_r;
  assign out_ch.pixel_value  = ob_smooth_r ? ob_val_r : ob_bit_r;
  assign out_ch.column_index = IDX_W'(col_sel);
  assign out_ch.row_index    = IDX_W'(ob_row_r);
  assign out_ch.last_of_run  = !(ob_smooth_r && ob_pass_r);
  assign out_ch.frame_end    = !ob_smooth_r && ob_fend_r;

endmodule

// File: sv/binary_majority_smoother.sv
// Streaming five point binary majority smoother for a column-major bit map. One pixel is
// accepted every cycle unless the result channel stalls; its result passes through the input
// register and the result register and leaves one column behind the input; the pixels of
// the last column also leave at once after it. Those pixels cause two words each, so while
// the last column streams in, the single result register holds the input back until both
// words of a pixel are out. Writing a size register restarts the frame; the column stores
// need no clearing after reset.
module binary_majority_smoother import bms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bms_in_if.sink               in_ch,
  bms_out_if.source            out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  scan_pos_t        pos;
  logic             restart;
  logic             accept;
  logic             raw_centre, raw_below, smoothed_left;
  logic             sm_wr_en, sm_wr_bit;
  logic [ROW_W-1:0] sm_wr_row;

  assign accept = in_ch.valid && in_ch.ready;

  // sizes and scan position
  bms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pos       (pos),
    .restart   (restart)
  );

  // column memories
  bms_column_store u_store (
    .clk           (clk),
    .accept        (accept),
    .pos           (pos),
    .noise_bit     (in_ch.noise_bit),
    .sm_wr_en      (sm_wr_en),
    .sm_wr_row     (sm_wr_row),
    .sm_wr_bit     (sm_wr_bit),
    .raw_centre    (raw_centre),
    .raw_below     (raw_below),
    .smoothed_left (smoothed_left)
  );

  // vote and result words
  bms_vote u_vote (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .pos           (pos),
    .restart       (restart),
    .raw_centre    (raw_centre),
    .raw_below     (raw_below),
    .smoothed_left (smoothed_left),
    .sm_wr_en      (sm_wr_en),
    .sm_wr_row     (sm_wr_row),
    .sm_wr_bit     (sm_wr_bit)
  );

endmodule

// File: sv/bms_checker.sv
// port level checks on the result channel of the majority smoother
module bms_port_checks (
  input logic       clk,
  input logic       rst_n,
  bms_out_if.source out_ch
);

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result word withdrawn while stalled");

  // the frame end word closes its run
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_end |-> out_ch.last_of_run)
    else $error("frame end on a word that is not last of its run");

  // the second word of a pair follows straight away
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_run |=> out_ch.valid)
    else $error("second word of a pair missing");

  // both words of a pair share the row
  a_pair_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_run |=>
      out_ch.row_index == $past(out_ch.row_index))
    else $error("pair of words on different rows");

endmodule

bind binary_majority_smoother bms_port_checks u_bms_port_checks (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);
